// ===== rtl/sci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_pkg: shared constants for the segment/circle intersection test
// Default coordinate width and the tolerance register layout.
// ----------------------------------------------------------------------------
package sci_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int TOL_BITS       = 16;
   localparam int TOL2_BITS      = 2 * TOL_BITS;
   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(26);
endpackage

// ===== rtl/sci_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_if: channel interfaces of the segment/circle intersection test
// Request, response and tolerance-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface sci_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic signed [COORD_BITS-1:0] centre_x;
   logic signed [COORD_BITS-1:0] centre_y;
   logic        [COORD_BITS-2:0] radius;
   modport source (output valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                   radius, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                   radius, output ready);
endinterface

interface sci_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

interface sci_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/sci_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_mul: two-stage unsigned multiplier
// Splits each operand in halves, registers four partial products, then sums.
// ----------------------------------------------------------------------------
module sci_mul #(
   parameter int A_BITS = 51,
   parameter int B_BITS = 51
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [A_BITS-1:0]          a,
   input  logic [B_BITS-1:0]          b,
   output logic [A_BITS+B_BITS-1:0]   p
);
   localparam int AL = (A_BITS + 1) / 2;
   localparam int AH = A_BITS - AL;
   localparam int BL = (B_BITS + 1) / 2;
   localparam int BH = B_BITS - BL;
   localparam int PW = A_BITS + B_BITS;

   logic [AL+BL-1:0] pp_ll_ff;
   logic [AL+BH-1:0] pp_lh_ff;
   logic [AH+BL-1:0] pp_hl_ff;
   logic [AH+BH-1:0] pp_hh_ff;
   logic [PW-1:0]    p_in;
   logic [PW-1:0]    p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= a[AL-1:0] * b[BL-1:0];
         pp_lh_ff <= a[AL-1:0] * b[B_BITS-1:BL];
         pp_hl_ff <= a[A_BITS-1:AL] * b[BL-1:0];
         pp_hh_ff <= a[A_BITS-1:AL] * b[B_BITS-1:BL];
         p_ff     <= p_in;
      end
   end

   always_comb begin
      p_in = PW'(pp_ll_ff)
           + (PW'(pp_lh_ff) << BL)
           + (PW'(pp_hl_ff) << AL)
           + (PW'(pp_hh_ff) << (AL + BL));
   end

   assign p = p_ff;
endmodule

// ===== rtl/segment_circle_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_circle_intersect: segment versus circle hit test
// Accepted request words pass through an eight-stage pipe, with two-stage split
// multipliers, to the response word. Throughput is one word per cycle while the
// response is not stalled. A stalled response holds the whole pipe.
// Reset clears all valid bits and sets the tolerance to 26.
// ----------------------------------------------------------------------------
module segment_circle_intersect #(
   parameter int COORD_BITS = sci_pkg::COORD_BITS_DEF
) (
   input logic    clock,
   input logic    reset,
   sci_req_if.sink   req_chan,
   sci_rsp_if.source rsp_chan,
   sci_csr_if.sink   csr_chan
);
   import sci_pkg::*;

   localparam int NSTAGE = 8;
   localparam int CW     = COORD_BITS;
   localparam int RW     = CW - 1;
   localparam int DW     = CW + 1;        // differences, signed; magnitudes unsigned
   localparam int SQW    = 2 * DW;        // one square or product
   localparam int SUMW   = SQW + 1;       // sum of two squares, |n|
   localparam int NW     = SUMW + 1;      // signed dot product
   localparam int R2W    = 2 * RW;
   localparam int WW     = 2 * SUMW;      // wide products
   localparam int CMPW   = WW + 2;

   logic               adv;
   logic [NSTAGE-1:0]  vld_ff;
   logic [TOL2_BITS-1:0] tol2_ff;

   assign adv            = !(vld_ff[NSTAGE-1] && !rsp_chan.ready);
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         tol2_ff <= TOL2_BITS'(TOL_RESET * TOL_RESET);
      end else begin
         if (adv) vld_ff <= {vld_ff[NSTAGE-2:0], req_chan.valid};
         if (csr_chan.valid) tol2_ff <= csr_chan.data * csr_chan.data;
      end
   end

   // Stage 1: differences as magnitude and sign.
   logic signed [DW-1:0] dx, dy, ax, ay, bx, by;
   logic [DW-1:0] mdx_ff, mdy_ff, max_ff, may_ff, mbx_ff, mby_ff;
   logic          sgx_ff, sgy_ff;
   logic [RW-1:0] rad_ff;

   function automatic logic [DW-1:0] magn(input logic signed [DW-1:0] v);
      magn = v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   always_comb begin
      dx = DW'(req_chan.end_x)    - DW'(req_chan.start_x);
      dy = DW'(req_chan.end_y)    - DW'(req_chan.start_y);
      ax = DW'(req_chan.centre_x) - DW'(req_chan.start_x);
      ay = DW'(req_chan.centre_y) - DW'(req_chan.start_y);
      bx = DW'(req_chan.centre_x) - DW'(req_chan.end_x);
      by = DW'(req_chan.centre_y) - DW'(req_chan.end_y);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mdx_ff <= magn(dx);
         mdy_ff <= magn(dy);
         max_ff <= magn(ax);
         may_ff <= magn(ay);
         mbx_ff <= magn(bx);
         mby_ff <= magn(by);
         sgx_ff <= ax[DW-1] ^ dx[DW-1];
         sgy_ff <= ay[DW-1] ^ dy[DW-1];
         rad_ff <= req_chan.radius;
      end
   end

   // Stage 2: squares and products.
   logic [SQW-1:0] sax_ff, say_ff, sbx_ff, sby_ff, sdx_ff, sdy_ff, pxd_ff, pyd_ff;
   logic [R2W-1:0] r2_ff;
   logic           sgx2_ff, sgy2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sax_ff  <= max_ff * max_ff;
         say_ff  <= may_ff * may_ff;
         sbx_ff  <= mbx_ff * mbx_ff;
         sby_ff  <= mby_ff * mby_ff;
         sdx_ff  <= mdx_ff * mdx_ff;
         sdy_ff  <= mdy_ff * mdy_ff;
         pxd_ff  <= max_ff * mdx_ff;
         pyd_ff  <= may_ff * mdy_ff;
         r2_ff   <= rad_ff * rad_ff;
         sgx2_ff <= sgx_ff;
         sgy2_ff <= sgy_ff;
      end
   end

   // Stage 3: squared distances, squared length and the signed dot product.
   logic signed [NW-1:0] tx, ty;
   logic [SUMW-1:0] da_ff, db_ff, len2_ff;
   logic signed [NW-1:0] n_ff;
   logic [R2W-1:0]  r2b_ff;

   always_comb begin
      tx = sgx2_ff ? -$signed(NW'(pxd_ff)) : $signed(NW'(pxd_ff));
      ty = sgy2_ff ? -$signed(NW'(pyd_ff)) : $signed(NW'(pyd_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         da_ff   <= SUMW'(sax_ff) + SUMW'(say_ff);
         db_ff   <= SUMW'(sbx_ff) + SUMW'(sby_ff);
         len2_ff <= SUMW'(sdx_ff) + SUMW'(sdy_ff);
         n_ff    <= tx + ty;
         r2b_ff  <= r2_ff;
      end
   end

   // Stage 4: endpoint test and overshoot of the projection past the segment.
   logic            n_neg;
   logic [SUMW-1:0] nabs_in, m_in;
   logic [SUMW-1:0] nabs_ff, m_ff, da4_ff, len4_ff;
   logic [R2W-1:0]  r24_ff;
   logic            ins4_ff, nz4_ff;

   always_comb begin
      n_neg   = n_ff[NW-1];
      nabs_in = n_neg ? SUMW'(-n_ff) : SUMW'(n_ff);
      if (n_neg) begin
         m_in = nabs_in;
      end else if (nabs_in > len2_ff) begin
         m_in = nabs_in - len2_ff;
      end else begin
         m_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nabs_ff <= nabs_in;
         m_ff    <= m_in;
         da4_ff  <= da_ff;
         len4_ff <= len2_ff;
         r24_ff  <= r2b_ff;
         ins4_ff <= (SUMW'(r2b_ff) >= da_ff) || (SUMW'(r2b_ff) >= db_ff);
         nz4_ff  <= len2_ff != '0;
      end
   end

   // Stages 5 and 6: wide products in the split multipliers.
   logic [WW-1:0]             mm, dl, nn;
   logic [TOL2_BITS+SUMW-1:0] tl;
   logic [R2W+SUMW-1:0]       rl;
   logic [1:0]                ins_p_ff, nz_p_ff;

   sci_mul #(.A_BITS(SUMW), .B_BITS(SUMW)) u_mul_mm (
      .clock(clock), .en(adv), .a(m_ff), .b(m_ff), .p(mm));
   sci_mul #(.A_BITS(SUMW), .B_BITS(SUMW)) u_mul_nn (
      .clock(clock), .en(adv), .a(nabs_ff), .b(nabs_ff), .p(nn));
   sci_mul #(.A_BITS(SUMW), .B_BITS(SUMW)) u_mul_dl (
      .clock(clock), .en(adv), .a(da4_ff), .b(len4_ff), .p(dl));
   sci_mul #(.A_BITS(TOL2_BITS), .B_BITS(SUMW)) u_mul_tl (
      .clock(clock), .en(adv), .a(tol2_ff), .b(len4_ff), .p(tl));
   sci_mul #(.A_BITS(R2W), .B_BITS(SUMW)) u_mul_rl (
      .clock(clock), .en(adv), .a(r24_ff), .b(len4_ff), .p(rl));

   always_ff @(posedge clock) begin
      if (adv) begin
         ins_p_ff <= {ins_p_ff[0], ins4_ff};
         nz_p_ff  <= {nz_p_ff[0], nz4_ff};
      end
   end

   // Stage 7: tolerance test and the right side of the distance test.
   logic [WW-1:0]   dl7_ff;
   logic [WW:0]     rhs7_ff;
   logic            onseg7_ff, ins7_ff, nz7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         onseg7_ff <= (CMPW'(mm) << 2) <= CMPW'(tl);
         dl7_ff    <= dl;
         rhs7_ff   <= (WW + 1)'(rl) + (WW + 1)'(nn);
         ins7_ff   <= ins_p_ff[1];
         nz7_ff    <= nz_p_ff[1];
      end
   end

   // Stage 8: response register.
   logic hit_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= ins7_ff || (nz7_ff && onseg7_ff && ((WW + 1)'(dl7_ff) <= rhs7_ff));
      end
   end

   assign rsp_chan.valid = vld_ff[NSTAGE-1];
   assign rsp_chan.hit   = hit_ff;
endmodule

// ===== bench/segment_circle_intersect_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_circle_intersect_tb: self-checking bench for the hit test
// Drives directed and random segment/circle words through the request
// channel, predicts each hit flag with exact wide integer math, and checks
// responses in order under several idle and stall phases and tolerances.
// ----------------------------------------------------------------------------
module segment_circle_intersect_tb;
   import sci_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 20;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic signed [127:0] wide_s_type;
   typedef logic [255:0] wide_u_type;

   typedef struct {
      coord_type sx, sy, ex, ey, cx, cy;
      logic [CB-2:0] r;
   } seg_word_type;

   class hit_scoreboard;
      bit pending_hits[$];
      int errors;
      logic [TOL_BITS-1:0] tol;

      function new();
         errors = 0;
         tol = TOL_RESET;
      endfunction

      function bit predict_hit(seg_word_type w);
         wide_s_type dx, dy, ax, ay, bx, by, n, m;
         wide_u_type r2, da, db, len2, tol2l, nmag;
         dx = wide_s_type'(w.ex) - wide_s_type'(w.sx);
         dy = wide_s_type'(w.ey) - wide_s_type'(w.sy);
         ax = wide_s_type'(w.cx) - wide_s_type'(w.sx);
         ay = wide_s_type'(w.cy) - wide_s_type'(w.sy);
         bx = wide_s_type'(w.cx) - wide_s_type'(w.ex);
         by = wide_s_type'(w.cy) - wide_s_type'(w.ey);
         r2 = wide_u_type'(w.r) * wide_u_type'(w.r);
         da = wide_u_type'(ax * ax) + wide_u_type'(ay * ay);
         db = wide_u_type'(bx * bx) + wide_u_type'(by * by);
         if (da <= r2 || db <= r2) return 1'b1;
         len2 = wide_u_type'(dx * dx) + wide_u_type'(dy * dy);
         if (len2 == 0) return 1'b0;
         n = ax * dx + ay * dy;
         tol2l = wide_u_type'(tol) * wide_u_type'(tol) * len2;
         if (n < 0) begin
            nmag = wide_u_type'(-n);
            if (4 * nmag * nmag > tol2l) return 1'b0;
         end else begin
            nmag = wide_u_type'(n);
            if (nmag > len2) begin
               m = n - wide_s_type'(len2);
               if (4 * wide_u_type'(m) * wide_u_type'(m) > tol2l) return 1'b0;
            end
         end
         return (da * len2 <= r2 * len2 + nmag * nmag);
      endfunction

      function void note_request(seg_word_type w);
         pending_hits.push_back(predict_hit(w));
      endfunction

      task check_response(logic hit);
         bit exp_hit;
         if (pending_hits.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            exp_hit = pending_hits.pop_front();
            if (hit !== exp_hit)
               report_mismatch($sformatf("hit %b, expected %b", hit, exp_hit));
         end
      endtask

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask
   endclass

   logic clock, reset;
   sci_req_if #(.COORD_BITS(CB)) req_chan();
   sci_rsp_if rsp_chan();
   sci_csr_if csr_chan();

   segment_circle_intersect #(.COORD_BITS(CB)) uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   hit_scoreboard sb = new();
   int send_idle_pct, recv_stall_pct;
   int idle_cycles;
   bit done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stall, check on every accepted response word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) sb.check_response(rsp_chan.hit);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready) || done) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Valid stays high between back-to-back words; it drops only on idle cycles.
   task send_word(seg_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.start_x <= w.sx;
      req_chan.start_y <= w.sy;
      req_chan.end_x <= w.ex;
      req_chan.end_y <= w.ey;
      req_chan.centre_x <= w.cx;
      req_chan.centre_y <= w.cy;
      req_chan.radius <= w.r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(w);
   endtask

   task wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_tolerance(logic [TOL_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      sb.tol = value;
   endtask

   function coord_type rand_coord(int span);
      case ($urandom_range(3))
         0: rand_coord = coord_type'($urandom);
         default: rand_coord = coord_type'($signed($urandom_range(2 * span)) - span);
      endcase
   endfunction

   // Mostly segments near a circle of similar size, so all branches occur.
   function seg_word_type rand_word();
      seg_word_type w;
      int span;
      span = 1 << $urandom_range(20, 4);
      w.cx = rand_coord(span);
      w.cy = rand_coord(span);
      w.sx = w.cx + rand_coord(span);
      w.sy = w.cy + rand_coord(span);
      case ($urandom_range(9))
         0: begin
            w.ex = w.sx;
            w.ey = w.sy;
         end
         1: begin
            w.ex = rand_coord(span);
            w.ey = rand_coord(span);
         end
         default: begin
            w.ex = w.cx + rand_coord(span);
            w.ey = w.cy + rand_coord(span);
         end
      endcase
      case ($urandom_range(5))
         0: w.r = (CB-1)'($urandom);
         1: w.r = '0;
         default: w.r = (CB-1)'($urandom_range(span));
      endcase
      return w;
   endfunction

   function seg_word_type make_word(coord_type sx, coord_type sy, coord_type ex,
                                    coord_type ey, coord_type cx, coord_type cy,
                                    logic [CB-2:0] r);
      seg_word_type w;
      w.sx = sx; w.sy = sy; w.ex = ex; w.ey = ey; w.cx = cx; w.cy = cy; w.r = r;
      return w;
   endfunction

   localparam coord_type CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic [CB-2:0] RMAX = '1;

   initial begin
      int phase;
      done = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.start_x = '0; req_chan.start_y = '0;
      req_chan.end_x = '0; req_chan.end_y = '0;
      req_chan.centre_x = '0; req_chan.centre_y = '0;
      req_chan.radius = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset tolerance.
      send_word(make_word(0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(256, 256, 256, 256, 0, 0, 100));
      send_word(make_word(256, 256, 256, 256, 0, 0, 400));
      send_word(make_word(-2560, 512, 2560, 512, 0, 0, 512));
      send_word(make_word(-2560, 512, 2560, 512, 0, 0, 511));
      send_word(make_word(-2560, 0, -1280, 0, 0, 0, 100));
      send_word(make_word(-2560, 10, -20, 10, 0, 0, 11));
      send_word(make_word(-2560, 10, -20, 10, 0, 0, 9));
      send_word(make_word(CMIN, CMIN, CMAX, CMAX, 0, 0, 0));
      send_word(make_word(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, RMAX));
      send_word(make_word(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, RMAX));
      send_word(make_word(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, RMAX));
      send_word(make_word(CMAX, 0, CMIN, 0, 0, CMAX, RMAX));
      send_word(make_word(0, -1, -1, 0, 0, 0, 1));
      send_word(make_word(-1, -1, -1, -1, 0, 0, 0));
      wait_drained();
      write_tolerance('1);
      send_word(make_word(-2560, 0, -1280, 0, 0, 0, 100));
      send_word(make_word(CMAX, 0, CMIN, 0, 0, CMAX, RMAX));
      wait_drained();
      write_tolerance('0);
      send_word(make_word(-2560, 10, -20, 10, 0, 0, 11));
      send_word(make_word(-2560, 0, 2560, 0, 0, 0, 1));

      for (phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 88; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 88; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         case (phase)
            0: write_tolerance('0);
            1: write_tolerance('1);
            2: write_tolerance(TOL_RESET);
            default: write_tolerance((phase & 1) ? TOL_BITS'($urandom_range(2000))
                                                 : TOL_BITS'($urandom));
         endcase
         repeat (105) send_word(rand_word());
      end

      wait_drained();
      done = 1'b1;
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
